// File: sv/number_to_ascii_formatter_macros.svh
// ----------------------------------------------------------------------------
// number_to_ascii_formatter assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef NUMBER_TO_ASCII_FORMATTER_MACROS_SVH
`define NUMBER_TO_ASCII_FORMATTER_MACROS_SVH

// same-cycle implication, off while in reset
`define N2A_ASSERT_IMP(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!(r)) (ante) |-> (cons)) \
    else $error("n2a check failed");

// next-cycle implication, off while in reset
`define N2A_ASSERT_NEXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!(r)) (ante) |=> (cons)) \
    else $error("n2a check failed");

// next-cycle implication that also runs through reset
`define N2A_ASSERT_NEXT_ALL(lbl, c, ante, cons) \
  lbl: assert property (@(posedge c) (ante) |=> (cons)) \
    else $error("n2a check failed");

`endif

// File: sv/n2a_pkg.sv
// ----------------------------------------------------------------------------
// n2a_pkg
// types and constants shared by the number to ascii formatter
// ----------------------------------------------------------------------------
package n2a_pkg;

  localparam int BIN_W      = 32;
  localparam int DEC_DIGITS = 10;
  localparam int DIG_W      = DEC_DIGITS * 4;

  localparam logic [1:0] FUNC_HEX_BYTE = 2'd0;
  localparam logic [1:0] FUNC_HEX_WORD = 2'd1;
  localparam logic [1:0] FUNC_HEX_LONG = 2'd2;
  localparam logic [1:0] FUNC_DEC      = 2'd3;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_A    = 8'h41;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CONV,
    FS_PUSH
  } front_state_t;

  // one number, digits right-aligned, ndig counts the digits to print
  typedef struct packed {
    logic [DIG_W-1:0] digits;
    logic [3:0]       ndig;
  } job_t;

  function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'b0, d};
    end else begin
      c = CHAR_A + {4'b0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// File: sv/n2a_front.sv
// ----------------------------------------------------------------------------
// n2a_front
// accepts numbers, picks the format and builds the digit string
// ----------------------------------------------------------------------------
module n2a_front import n2a_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [1:0]       in_func,
  input  logic [BIN_W-1:0] in_value,
  output logic             q_push,
  output job_t             q_job,
  input  logic             q_full
);

  front_state_t     state_r, state_nxt;
  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic [DIG_W-1:0] bcd_r, bcd_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [3:0]       ndig_r, ndig_nxt;
  logic             is_dec_r, is_dec_nxt;
  logic [DIG_W-1:0] adj;

  function automatic logic [3:0] count_digits(input logic [DIG_W-1:0] d);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 1; i < DEC_DIGITS; i++) begin
      if (d[4*i +: 4] != 4'd0) n = 4'(i + 1);
    end
    return n;
  endfunction

  // double dabble: add 3 to every bcd digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                : bcd_r[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r    <= bin_nxt;
    bcd_r    <= bcd_nxt;
    cnt_r    <= cnt_nxt;
    ndig_r   <= ndig_nxt;
    is_dec_r <= is_dec_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    bin_nxt    = bin_r;
    bcd_nxt    = bcd_r;
    cnt_nxt    = cnt_r;
    ndig_nxt   = ndig_r;
    is_dec_nxt = is_dec_r;
    in_full    = (state_r != FS_IDLE);
    q_push     = 1'b0;
    q_job.digits = bcd_r;
    q_job.ndig   = is_dec_r ? count_digits(bcd_r) : ndig_r;
    unique case (state_r)
      FS_IDLE: begin
        if (in_push) begin
          is_dec_nxt = 1'b0;
          state_nxt  = FS_PUSH;
          unique case (in_func)
            FUNC_HEX_BYTE: begin
              bcd_nxt  = DIG_W'(in_value[7:0]);
              ndig_nxt = 4'd2;
            end
            FUNC_HEX_WORD: begin
              bcd_nxt  = DIG_W'(in_value[15:0]);
              ndig_nxt = 4'd4;
            end
            FUNC_HEX_LONG: begin
              bcd_nxt  = DIG_W'(in_value);
              ndig_nxt = 4'd8;
            end
            FUNC_DEC: begin
              bin_nxt    = in_value;
              bcd_nxt    = '0;
              cnt_nxt    = 5'd31;
              is_dec_nxt = 1'b1;
              state_nxt  = FS_CONV;
            end
          endcase
        end
      end
      FS_CONV: begin
        bcd_nxt = {adj[DIG_W-2:0], bin_r[BIN_W-1]};
        bin_nxt = bin_r << 1;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) state_nxt = FS_PUSH;
      end
      FS_PUSH: begin
        q_push = !q_full;
        if (!q_full) state_nxt = FS_IDLE;
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

endmodule

// File: sv/n2a_fifo.sv
// ----------------------------------------------------------------------------
// n2a_fifo
// short queue of digit strings between front and back
// ----------------------------------------------------------------------------
module n2a_fifo import n2a_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output job_t rd_job,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: sv/n2a_back.sv
// ----------------------------------------------------------------------------
// n2a_back
// emits one ascii character per word from the queued digit strings
// ----------------------------------------------------------------------------
module n2a_back import n2a_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       q_job,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_char_code,
  output logic       out_last
);

  logic [DIG_W-1:0] sh_r, sh_nxt;
  logic [3:0]       rem_r, rem_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;
  logic             slot_free;
  logic [3:0]       lead;
  logic [5:0]       shamt;

  assign out_empty     = !out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;
  assign slot_free     = !out_valid_r || out_pop;

  // left-align so the first digit sits in the top nibble
  assign lead  = 4'(DEC_DIGITS) - q_job.ndig;
  assign shamt = {lead, 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    sh_nxt        = sh_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    priority if (rem_r != 4'd0) begin
      if (slot_free) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = digit_to_ascii(sh_r[DIG_W-1 -: 4]);
        out_last_nxt  = (rem_r == 4'd1);
        sh_nxt        = sh_r << 4;
        rem_nxt       = rem_r - 4'd1;
      end
    end else if (!q_empty) begin
      q_pop   = 1'b1;
      sh_nxt  = q_job.digits << shamt;
      rem_nxt = q_job.ndig;
    end
  end

endmodule

// File: sv/number_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// number_to_ascii_formatter
// prints a 32-bit number as hex or unsigned decimal ascii characters
// ----------------------------------------------------------------------------
// Input queue: in_push with in_func and in_value, taken when in_full is low.
// Result queue: out_char_code and out_last are valid while out_empty is low,
// and the word is taken when out_pop is high. One word per character, most
// significant first, out_last on the final one.
// The front takes one number at a time and keeps in_full high until the
// number is written to the queue. A hex number goes from the accept state
// straight to the queue write; a decimal number first runs the bit-serial
// binary to bcd double dabble loop, which shifts in one input bit at a time.
// The back pulls a digit string from the queue, loads it into its shift
// register and then sends one character per cycle while the receiver pops.
// With the queue holding QUEUE_DEPTH strings, the front keeps converting
// while the back is still printing or the receiver stalls; a stalled
// receiver fills the queue and then holds in_full high.
// Reset empties the queue and the output register and leaves the front idle.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter import n2a_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [1:0]       in_func,
  input  logic [BIN_W-1:0] in_value,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [7:0]       out_char_code,
  output logic             out_last
);

  logic q_push, q_full, q_pop, q_empty;
  job_t wr_job, rd_job;

  n2a_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_func  (in_func),
    .in_value (in_value),
    .q_push   (q_push),
    .q_job    (wr_job),
    .q_full   (q_full)
  );

  n2a_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (rd_job),
    .empty  (q_empty)
  );

  n2a_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_job         (rd_job),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule

// File: sv/n2a_checker.sv
// ----------------------------------------------------------------------------
// n2a_checker
// port-level checks for the number to ascii formatter
// ----------------------------------------------------------------------------
`include "number_to_ascii_formatter_macros.svh"

module n2a_checker import n2a_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_char_code,
  input logic       out_last
);

  logic       is_hex_char;
  logic       out_stall;
  logic [8:0] out_word;

  assign is_hex_char = (out_char_code >= CHAR_ZERO && out_char_code <= CHAR_ZERO + 8'd9) ||
                       (out_char_code >= CHAR_A && out_char_code <= CHAR_A + 8'd5);
  assign out_stall   = !out_empty && !out_pop;
  assign out_word    = {out_last, out_char_code};

  `N2A_ASSERT_NEXT_ALL(a_reset_clear, clk, !rst_n, out_empty && !in_full)

  `N2A_ASSERT_IMP(a_hex_char, clk, rst_n, !out_empty, is_hex_char)

  `N2A_ASSERT_NEXT(a_hold, clk, rst_n, out_stall, !out_empty && $stable(out_word))

endmodule

bind number_to_ascii_formatter n2a_checker u_n2a_checker (.*);
